// File: rtl/afs_pkg.sv
// Shared constants, codes, types and helpers of the arming failsafe supervisor.
package afs_pkg;

  localparam int unsigned TIME_BITS  = 48;
  localparam int unsigned TMO_W      = 24;
  localparam int unsigned LVL_W      = 16;
  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned STATE_W    = 2;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CAUSE_W    = 3;
  localparam int unsigned OFF_W      = 10;
  localparam int unsigned ROLL_W     = 13;
  localparam int unsigned THR_W      = 10;
  localparam int unsigned YAW_W      = 12;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned IN_FIELDS_W  = TIME_BITS + REQ_W + 2 + 5 * PULSE_W;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = STATE_W + 1 + 2 * ROLL_W + THR_W + YAW_W + CAUSE_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_CHECK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ESTOP     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ARM_REQ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SETPOINT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RECEIVER  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FAULT     = 3'd6;

  localparam logic [STATE_W-1:0] ST_DISARMED = 2'd0;
  localparam logic [STATE_W-1:0] ST_ARMED    = 2'd1;
  localparam logic [STATE_W-1:0] ST_FAILSAFE = 2'd2;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE      = 3'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_ESTOP     = 3'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_SWITCH    = 3'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_SETPOINT  = 3'd3;
  localparam logic [CAUSE_W-1:0] CAUSE_HEARTBEAT = 3'd4;
  localparam logic [CAUSE_W-1:0] CAUSE_LINK      = 3'd5;
  localparam logic [CAUSE_W-1:0] CAUSE_FAULT     = 3'd6;

  localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT_TMO  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEARTBEAT_TMO = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LINK_TMO      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ARM_LEVEL     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_THROTTLE_LOW  = 3'd4;

  localparam logic [TMO_W-1:0] RST_SETPOINT_TMO  = 24'd300000;
  localparam logic [TMO_W-1:0] RST_HEARTBEAT_TMO = 24'd500000;
  localparam logic [TMO_W-1:0] RST_LINK_TMO      = 24'd120000;
  localparam logic [LVL_W-1:0] RST_ARM_LEVEL     = 16'd1500;
  localparam logic [LVL_W-1:0] RST_THROTTLE_LOW  = 16'd1100;

  localparam logic [PULSE_W-1:0] PULSE_MIN = 16'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MAX = 16'd2000;

  localparam logic [ROLL_W-1:0] ROLL_BIAS = 13'd3000;
  localparam logic [YAW_W-1:0]  YAW_BIAS  = 12'd1500;

  typedef struct packed {
    logic [ROLL_W-1:0] roll;
    logic [ROLL_W-1:0] pitch;
    logic [THR_W-1:0]  throttle;
    logic [YAW_W-1:0]  yaw;
  } rc_setpoint_t;

  function automatic logic [OFF_W-1:0] clamp_offset(input logic [PULSE_W-1:0] pulse);
    logic [PULSE_W-1:0] p;
    p = pulse;
    if (p < PULSE_MIN) p = PULSE_MIN;
    if (p > PULSE_MAX) p = PULSE_MAX;
    return OFF_W'(p - PULSE_MIN);
  endfunction

endpackage

// File: rtl/afs_rc_map.sv
// Receiver pulse to fixed-point setpoint mapping for four stick channels.
module afs_rc_map (
  input  logic [afs_pkg::PULSE_W-1:0] ch_roll_i,
  input  logic [afs_pkg::PULSE_W-1:0] ch_pitch_i,
  input  logic [afs_pkg::PULSE_W-1:0] ch_throttle_i,
  input  logic [afs_pkg::PULSE_W-1:0] ch_yaw_i,
  output afs_pkg::rc_setpoint_t       setpoint_o
);

  logic [afs_pkg::OFF_W-1:0]  off_roll, off_pitch, off_thr, off_yaw;
  logic [afs_pkg::ROLL_W-1:0] roll_x6, pitch_x6;
  logic [afs_pkg::YAW_W-1:0]  yaw_x3;

  always_comb begin
    off_roll  = afs_pkg::clamp_offset(ch_roll_i);
    off_pitch = afs_pkg::clamp_offset(ch_pitch_i);
    off_thr   = afs_pkg::clamp_offset(ch_throttle_i);
    off_yaw   = afs_pkg::clamp_offset(ch_yaw_i);

    roll_x6  = {1'b0, off_roll, 2'b00} + {2'b00, off_roll, 1'b0};
    pitch_x6 = {1'b0, off_pitch, 2'b00} + {2'b00, off_pitch, 1'b0};
    yaw_x3   = {1'b0, off_yaw, 1'b0} + {2'b00, off_yaw};

    setpoint_o.roll     = roll_x6 - afs_pkg::ROLL_BIAS;
    setpoint_o.pitch    = pitch_x6 - afs_pkg::ROLL_BIAS;
    setpoint_o.throttle = off_thr;
    setpoint_o.yaw      = yaw_x3 - afs_pkg::YAW_BIAS;
  end

endmodule

// File: rtl/arming_failsafe_supervisor_unit.sv
// Top level of the arming failsafe supervisor: input stage, arm-state logic, result stage.
//
//   channel  | direction | transfer when           | payload
//   s_axis   | in        | tvalid & tready         | tuser command, tdata event fields
//   m_axis   | out       | tvalid & tready         | tuser new_setpoint, tdata result fields
//   cfg      | in        | cfg_we_i                | cfg_addr_i register, cfg_wdata_i value
//
// One event per clock unless m_axis stalls: input register, one pass of compare and map
// logic, result register. Result valid rises when the event enters the result register.
// The arm state and the three timestamps update as the event moves to the result register.
// A stalled m_axis holds the result; s_axis keeps taking one more event into the input stage.
// Reset restores state, timestamps, valids and config registers, not payload registers.
module arming_failsafe_supervisor_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [2:0] command
  input  logic [afs_pkg::CMD_W-1:0]         s_axis_tuser,
  // [47:0] time_us, [49:48] arm_request, [50] fs_switch, [51] link_ok,
  // [67:52] ch_roll, [83:68] ch_pitch, [99:84] ch_throttle, [115:100] ch_yaw,
  // [131:116] ch_arm, [135:132] zero
  input  logic [afs_pkg::IN_DATA_W-1:0]     s_axis_tdata,

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] new_setpoint
  output logic                              m_axis_tuser,
  // [1:0] arm_state_out, [2] stop_motors, [15:3] roll_setpoint, [28:16] pitch_setpoint,
  // [38:29] throttle_setpoint, [50:39] yaw_rate_setpoint, [53:51] failsafe_cause,
  // [55:54] zero
  output logic [afs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,

  input  logic                              cfg_we_i,
  input  logic [afs_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [afs_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned TB = afs_pkg::TIME_BITS;
  localparam int unsigned PW = afs_pkg::PULSE_W;
  localparam int unsigned O_REQ  = TB;
  localparam int unsigned O_SW   = O_REQ + afs_pkg::REQ_W;
  localparam int unsigned O_LINK = O_SW + 1;
  localparam int unsigned O_ROLL = O_LINK + 1;
  localparam int unsigned O_PIT  = O_ROLL + PW;
  localparam int unsigned O_THR  = O_PIT + PW;
  localparam int unsigned O_YAW  = O_THR + PW;
  localparam int unsigned O_ARM  = O_YAW + PW;

  logic [afs_pkg::TMO_W-1:0] sp_tmo_q, hb_tmo_q, link_tmo_q;
  logic [afs_pkg::LVL_W-1:0] arm_lvl_q, thr_lvl_q;

  logic                           in_valid_q, in_valid_d;
  logic [afs_pkg::CMD_W-1:0]      cmd_q;
  logic [TB-1:0]                  time_q;
  logic [afs_pkg::REQ_W-1:0]      req_q;
  logic                           sw_q, link_q;
  logic [PW-1:0]                  ch_roll_q, ch_pitch_q, ch_thr_q, ch_yaw_q, ch_arm_q;

  logic [afs_pkg::STATE_W-1:0]    state_q, state_d;
  logic [TB-1:0]                  last_sp_q, last_sp_d;
  logic [TB-1:0]                  last_hb_q, last_hb_d;
  logic [TB-1:0]                  last_link_q, last_link_d;
  logic                           hb_seen_q, hb_seen_d;

  logic                           out_valid_q, out_valid_d;
  logic                           out_user_q;
  logic [afs_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                           s_xfer, advance;
  logic [TB-1:0]                  age_sp, age_hb, age_link;
  logic                           stale_sp, stale_hb, stale_link;
  logic                           sw_high, thr_low;
  logic                           stop, fresh;
  logic [afs_pkg::CAUSE_W-1:0]    cause;
  afs_pkg::rc_setpoint_t          rc_sp, sp_out;

  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_data_q;

  afs_rc_map u_rc_map (
    .ch_roll_i     (ch_roll_q),
    .ch_pitch_i    (ch_pitch_q),
    .ch_throttle_i (ch_thr_q),
    .ch_yaw_i      (ch_yaw_q),
    .setpoint_o    (rc_sp)
  );

  always_comb begin
    age_sp     = time_q - last_sp_q;
    age_hb     = time_q - last_hb_q;
    age_link   = time_q - last_link_q;
    stale_sp   = age_sp > TB'(sp_tmo_q);
    stale_hb   = hb_seen_q && (age_hb > TB'(hb_tmo_q));
    stale_link = age_link > TB'(link_tmo_q);
    sw_high    = ch_arm_q > arm_lvl_q;
    thr_low    = ch_thr_q <= thr_lvl_q;

    state_d     = state_q;
    last_sp_d   = last_sp_q;
    last_hb_d   = last_hb_q;
    last_link_d = last_link_q;
    hb_seen_d   = hb_seen_q;
    stop        = 1'b0;
    fresh       = 1'b0;
    cause       = afs_pkg::CAUSE_NONE;

    unique case (cmd_q)
      afs_pkg::CMD_CHECK: begin
        if (state_q == afs_pkg::ST_ARMED) begin
          if (stale_sp) cause = afs_pkg::CAUSE_SETPOINT;
          else if (stale_hb) cause = afs_pkg::CAUSE_HEARTBEAT;
          else if (stale_link) cause = afs_pkg::CAUSE_LINK;
        end
      end
      afs_pkg::CMD_ESTOP: begin
        cause = afs_pkg::CAUSE_ESTOP;
      end
      afs_pkg::CMD_ARM_REQ: begin
        if (req_q == afs_pkg::ST_DISARMED || req_q == afs_pkg::ST_ARMED ||
            req_q == afs_pkg::ST_FAILSAFE) begin
          state_d = req_q;
          stop    = (req_q != afs_pkg::ST_ARMED);
        end
      end
      afs_pkg::CMD_SETPOINT: begin
        last_sp_d = time_q;
      end
      afs_pkg::CMD_HEARTBEAT: begin
        last_hb_d = time_q;
        hb_seen_d = 1'b1;
      end
      afs_pkg::CMD_RECEIVER: begin
        if (link_q) last_link_d = time_q;
        if (sw_q) begin
          cause = afs_pkg::CAUSE_SWITCH;
        end else if (link_q) begin
          if (sw_high && thr_low && state_q == afs_pkg::ST_DISARMED) state_d = afs_pkg::ST_ARMED;
          if (!sw_high && state_q == afs_pkg::ST_ARMED) begin
            state_d = afs_pkg::ST_DISARMED;
            stop    = 1'b1;
          end
          fresh     = 1'b1;
          last_sp_d = time_q;
        end
      end
      afs_pkg::CMD_FAULT: begin
        cause = afs_pkg::CAUSE_FAULT;
      end
      default: begin
      end
    endcase

    if (cause != afs_pkg::CAUSE_NONE) begin
      state_d = afs_pkg::ST_FAILSAFE;
      stop    = 1'b1;
    end

    sp_out     = fresh ? rc_sp : '0;
    out_data_d = afs_pkg::OUT_DATA_W'({cause, sp_out.yaw, sp_out.throttle, sp_out.pitch,
                                       sp_out.roll, stop, state_d});

    in_valid_d  = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_tmo_q   <= afs_pkg::RST_SETPOINT_TMO;
      hb_tmo_q   <= afs_pkg::RST_HEARTBEAT_TMO;
      link_tmo_q <= afs_pkg::RST_LINK_TMO;
      arm_lvl_q  <= afs_pkg::RST_ARM_LEVEL;
      thr_lvl_q  <= afs_pkg::RST_THROTTLE_LOW;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        afs_pkg::REG_SETPOINT_TMO:  sp_tmo_q   <= cfg_wdata_i;
        afs_pkg::REG_HEARTBEAT_TMO: hb_tmo_q   <= cfg_wdata_i;
        afs_pkg::REG_LINK_TMO:      link_tmo_q <= cfg_wdata_i;
        afs_pkg::REG_ARM_LEVEL:     arm_lvl_q  <= cfg_wdata_i[afs_pkg::LVL_W-1:0];
        afs_pkg::REG_THROTTLE_LOW:  thr_lvl_q  <= cfg_wdata_i[afs_pkg::LVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= afs_pkg::ST_DISARMED;
      last_sp_q   <= '0;
      last_hb_q   <= '0;
      last_link_q <= '0;
      hb_seen_q   <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q     <= state_d;
        last_sp_q   <= last_sp_d;
        last_hb_q   <= last_hb_d;
        last_link_q <= last_link_d;
        hb_seen_q   <= hb_seen_d;
      end
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      cmd_q      <= s_axis_tuser;
      time_q     <= s_axis_tdata[TB-1:0];
      req_q      <= s_axis_tdata[O_REQ +: afs_pkg::REQ_W];
      sw_q       <= s_axis_tdata[O_SW];
      link_q     <= s_axis_tdata[O_LINK];
      ch_roll_q  <= s_axis_tdata[O_ROLL +: PW];
      ch_pitch_q <= s_axis_tdata[O_PIT +: PW];
      ch_thr_q   <= s_axis_tdata[O_THR +: PW];
      ch_yaw_q   <= s_axis_tdata[O_YAW +: PW];
      ch_arm_q   <= s_axis_tdata[O_ARM +: PW];
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
      out_user_q <= fresh;
    end
  end

endmodule
